// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define WSDF_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen outside reset
`define WSDF_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ===== rtl/core/wsdf_pkg.sv =====
// shared types and constants of the websocket frame deframer
`default_nettype none

package wsdf_pkg;

   localparam int unsigned LEN_W = 63;

   localparam logic KIND_HEADER  = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   localparam logic [6:0] LEN7_EXT16 = 7'd126;
   localparam logic [6:0] LEN7_EXT64 = 7'd127;

   typedef struct packed {
      logic             kind;
      logic [7:0]       payload_byte;
      logic             fin;
      logic [3:0]       frame_opcode;
      logic             masked;
      logic [LEN_W-1:0] payload_length;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/wsdf_parse.sv =====
// frame header parser and payload unmasking, one byte per accepted item
`default_nettype none

`include "assert_macros.svh"

module wsdf_parse (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       rx_byte,
   output logic                  res_valid,
   output wsdf_pkg::rsp_type     res
);

   localparam logic [2:0] PH_BYTE1   = 3'd0;
   localparam logic [2:0] PH_BYTE2   = 3'd1;
   localparam logic [2:0] PH_LEN16   = 3'd2;
   localparam logic [2:0] PH_LEN64   = 3'd3;
   localparam logic [2:0] PH_KEY     = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;

   localparam int unsigned LW = wsdf_pkg::LEN_W;

   logic [2:0]    phase_ff, phase_in;
   logic          fin_ff, fin_in;
   logic [3:0]    opcode_ff, opcode_in;
   logic          mask_ff, mask_in;
   logic [LW-1:0] len_ff, len_in;
   logic [2:0]    count_ff, count_in;
   logic [31:0]   key_ff, key_in;
   logic [LW-1:0] left_ff, left_in;
   logic [1:0]    kidx_ff, kidx_in;

   logic [2:0]    count_inc;
   logic [6:0]    len7;
   logic [7:0]    key_byte;
   logic          do_after;
   logic          do_finish;
   logic          emit;
   logic          kind;
   logic [7:0]    out_byte;
   logic          last;

   assign count_inc = count_ff + 3'd1;
   assign len7      = rx_byte[6:0];

   always_comb begin
      unique case (kidx_ff)
         2'd0: key_byte = key_ff[31:24];
         2'd1: key_byte = key_ff[23:16];
         2'd2: key_byte = key_ff[15:8];
         2'd3: key_byte = key_ff[7:0];
         default: key_byte = 8'h00;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      len_in    = len_ff;
      count_in  = count_ff;
      key_in    = key_ff;
      left_in   = left_ff;
      kidx_in   = kidx_ff;
      do_after  = 1'b0;
      do_finish = 1'b0;
      emit      = 1'b0;
      kind      = wsdf_pkg::KIND_HEADER;
      out_byte  = 8'h00;
      last      = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PH_BYTE1: begin
               fin_in    = rx_byte[7];
               opcode_in = rx_byte[3:0];
               phase_in  = PH_BYTE2;
            end
            PH_BYTE2: begin
               mask_in  = rx_byte[7];
               count_in = 3'd0;
               if (len7 == wsdf_pkg::LEN7_EXT16) begin
                  len_in   = '0;
                  phase_in = PH_LEN16;
               end else if (len7 == wsdf_pkg::LEN7_EXT64) begin
                  len_in   = '0;
                  phase_in = PH_LEN64;
               end else begin
                  len_in   = {{(LW-7){1'b0}}, len7};
                  do_after = 1'b1;
               end
            end
            PH_LEN16: begin
               len_in   = {{(LW-16){1'b0}}, len_ff[7:0], rx_byte};
               count_in = count_inc;
               do_after = (count_inc == 3'd2);
            end
            PH_LEN64: begin
               len_in = {len_ff[LW-9:0], rx_byte};
               if (count_ff == 3'd7) begin
                  count_in = 3'd0;
                  do_after = 1'b1;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_KEY: begin
               key_in    = {key_ff[23:0], rx_byte};
               count_in  = count_inc;
               do_finish = (count_inc == 3'd4);
            end
            PH_PAYLOAD: begin
               emit     = 1'b1;
               kind     = wsdf_pkg::KIND_PAYLOAD;
               out_byte = mask_ff ? (rx_byte ^ key_byte) : rx_byte;
               last     = (left_ff[LW-1:1] == '0);
               kidx_in  = kidx_ff + 2'd1;
               if (last) begin
                  left_in  = '0;
                  phase_in = PH_BYTE1;
               end else begin
                  left_in = left_ff - {{(LW-1){1'b0}}, 1'b1};
               end
            end
            default: begin
               phase_in = PH_BYTE1;
            end
         endcase
      end
      if (do_after) begin
         if (mask_in) begin
            phase_in = PH_KEY;
            count_in = 3'd0;
            key_in   = '0;
         end else begin
            do_finish = 1'b1;
         end
      end
      if (do_finish) begin
         left_in  = len_in;
         kidx_in  = 2'd0;
         count_in = 3'd0;
         emit     = 1'b1;
         last     = (len_in == '0);
         phase_in = last ? PH_BYTE1 : PH_PAYLOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BYTE1;
         fin_ff    <= 1'b0;
         opcode_ff <= '0;
         mask_ff   <= 1'b0;
         len_ff    <= '0;
         count_ff  <= '0;
         key_ff    <= '0;
         left_ff   <= '0;
         kidx_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         len_ff    <= len_in;
         count_ff  <= count_in;
         key_ff    <= key_in;
         left_ff   <= left_in;
         kidx_ff   <= kidx_in;
      end
   end

   assign res_valid          = emit;
   assign res.kind           = kind;
   assign res.payload_byte   = out_byte;
   assign res.fin            = fin_in;
   assign res.frame_opcode   = opcode_in;
   assign res.masked         = mask_in;
   assign res.payload_length = len_in;
   assign res.last           = last;

   `WSDF_ASSERT(a_payload_left, (phase_ff == PH_PAYLOAD) |-> (left_ff != '0), "payload phase with no bytes left")
   `WSDF_ASSERT(a_key_count, (phase_ff == PH_KEY) |-> (count_ff < 3'd4), "key byte count overrun")
   `WSDF_ASSERT(a_len16_count, (phase_ff == PH_LEN16) |-> (count_ff < 3'd2), "16-bit length count overrun")
   `WSDF_NEVER(a_emit_idle, res_valid && !accept, "result without an accepted item")

endmodule

`default_nettype wire

// ===== rtl/core/wsdf_outbuf.sv =====
// result register with a skid stage so input stall is a registered signal
`default_nettype none

`include "assert_macros.svh"

module wsdf_outbuf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire wsdf_pkg::rsp_type in_data,
   output logic                   in_stall,
   output logic                   out_valid,
   output wsdf_pkg::rsp_type      out_data,
   input  wire logic              out_stall
);

   logic              out_valid_ff, out_valid_in;
   wsdf_pkg::rsp_type out_data_ff, out_data_in;
   logic              skid_valid_ff, skid_valid_in;
   wsdf_pkg::rsp_type skid_data_ff, skid_data_in;
   logic              out_free;

   assign out_free = !out_valid_ff || !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (!out_stall) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (out_free) begin
            out_valid_in = 1'b1;
            out_data_in  = in_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = in_data;
         end
      end else if (!out_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   `WSDF_ASSERT(a_skid_behind_out, skid_valid_ff |-> out_valid_ff, "skid holds an item ahead of output")
   `WSDF_ASSERT(a_skid_fill, $rose(skid_valid_ff) |-> $past(out_valid_ff && out_stall), "skid filled while output was free")
   `WSDF_NEVER(a_in_while_full, in_valid && skid_valid_ff, "item offered while skid full")

endmodule

`default_nettype wire

// ===== rtl/core/websocket_frame_deframer.sv =====
// top level of the websocket frame deframer
// Takes a received WebSocket stream one byte per item and emits one header
// item when a frame header is complete (fin, opcode, mask flag, decoded
// 63-bit length), then one item per payload byte, unmasked with the frame's
// key and flagged last on the final byte (or on the header of an empty
// frame). Header bytes other than the one that completes the header give no
// item. Throughput is one byte per clock while req_stall is low: the parser
// state updates at the edge that accepts a byte, and that byte's result is
// captured at the same edge: in the output register if free (offered on the
// rsp_ ports from the next cycle on), else in the one-entry skid stage
// behind it. The skid keeps req_stall a registered signal; it rises the
// cycle after a result arrives while the output register holds a stalled
// item, and falls once the skid entry has moved into the output register.
`default_nettype none

module websocket_frame_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_fin,
   output logic [3:0]       rsp_frame_opcode,
   output logic             rsp_masked,
   output logic [62:0]      rsp_payload_length,
   output logic             rsp_last
);

   logic              accept;
   logic              res_valid;
   wsdf_pkg::rsp_type res;
   wsdf_pkg::rsp_type out_data;

   assign accept = req_valid && !req_stall;

   wsdf_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   wsdf_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .out_stall (rsp_stall)
   );

   assign rsp_kind           = out_data.kind;
   assign rsp_payload_byte   = out_data.payload_byte;
   assign rsp_fin            = out_data.fin;
   assign rsp_frame_opcode   = out_data.frame_opcode;
   assign rsp_masked         = out_data.masked;
   assign rsp_payload_length = out_data.payload_length;
   assign rsp_last           = out_data.last;

endmodule

`default_nettype wire

// ===== tb/websocket_frame_deframer_test.sv =====
// self-checking testbench for the websocket frame deframer
`timescale 1ns / 100ps

module websocket_frame_deframer_test;

   localparam int RANDOM_BYTES = 900;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int HOLD_CYCLES = 400;

   typedef enum logic [2:0] {
      P_HDR0, P_HDR1, P_EXT16, P_EXT64, P_KEY, P_DATA
   } parse_phase_type;

   typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_type;

   typedef struct packed {
      logic [7:0]        rx_byte;
      logic              typed;
      wsdf_pkg::rsp_type want;
   } stim_row_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_fin;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_masked;
   logic [62:0] rsp_payload_length;
   logic        rsp_last;

   websocket_frame_deframer DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_fin            (rsp_fin),
      .rsp_frame_opcode   (rsp_frame_opcode),
      .rsp_masked         (rsp_masked),
      .rsp_payload_length (rsp_payload_length),
      .rsp_last           (rsp_last)
   );

   // deframer state as predicted
   parse_phase_type frame_phase = P_HDR0;
   logic            frame_fin = 1'b0;
   logic [3:0]      frame_op = 4'h0;
   logic            frame_mask = 1'b0;
   logic [63:0]     frame_len = 64'd0;
   logic [2:0]      hdr_count = 3'd0;
   logic [31:0]     frame_key = 32'd0;
   logic [62:0]     bytes_remaining = 63'd0;
   logic [1:0]      key_pos = 2'd0;

   stim_row_type      stimulus[$];
   stim_row_type      directed_rows [25];
   wsdf_pkg::rsp_type awaited_items[$];

   int   cycle = 0;
   int   mismatches = 0;
   int   accepted_bytes = 0;
   int   frames_built = 0;
   int   headers_seen = 0;
   int   payload_seen = 0;
   int   hold_run = 0;
   int   longest_hold = 0;
   logic held_off = 1'b0;
   logic stim_done = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic wsdf_pkg::rsp_type frame_item(input logic kind, input logic [7:0] pb,
                                                    input logic fin_last);
      wsdf_pkg::rsp_type r;
      r.kind = kind;
      r.payload_byte = pb;
      r.fin = frame_fin;
      r.frame_opcode = frame_op;
      r.masked = frame_mask;
      r.payload_length = frame_len[62:0];
      r.last = fin_last;
      return r;
   endfunction

   task automatic header_done(output logic emitted, output wsdf_pkg::rsp_type res);
      frame_len[63] = 1'b0;
      bytes_remaining = frame_len[62:0];
      key_pos = 2'd0;
      hdr_count = 3'd0;
      emitted = 1'b1;
      res = frame_item(wsdf_pkg::KIND_HEADER, 8'h00, bytes_remaining == 63'd0);
      frame_phase = (bytes_remaining == 63'd0) ? P_HDR0 : P_DATA;
   endtask

   task automatic length_done(output logic emitted, output wsdf_pkg::rsp_type res);
      emitted = 1'b0;
      res = '0;
      if (frame_mask) begin
         frame_phase = P_KEY;
         hdr_count = 3'd0;
         frame_key = 32'd0;
      end else begin
         header_done(emitted, res);
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b, output logic emitted,
                               output wsdf_pkg::rsp_type res);
      logic [7:0] kb;
      logic       fin_last;
      emitted = 1'b0;
      res = '0;
      case (frame_phase)
         P_HDR0: begin
            frame_fin = b[7];
            frame_op = b[3:0];
            frame_phase = P_HDR1;
         end
         P_HDR1: begin
            frame_mask = b[7];
            hdr_count = 3'd0;
            if (b[6:0] == wsdf_pkg::LEN7_EXT16) begin
               frame_len = 64'd0;
               frame_phase = P_EXT16;
            end else if (b[6:0] == wsdf_pkg::LEN7_EXT64) begin
               frame_len = 64'd0;
               frame_phase = P_EXT64;
            end else begin
               frame_len = {57'd0, b[6:0]};
               length_done(emitted, res);
            end
         end
         P_EXT16: begin
            frame_len = {48'd0, frame_len[7:0], b};
            hdr_count = hdr_count + 3'd1;
            if (hdr_count == 3'd2) length_done(emitted, res);
         end
         P_EXT64: begin
            frame_len = {frame_len[55:0], b};
            if (hdr_count == 3'd7) begin
               hdr_count = 3'd0;
               length_done(emitted, res);
            end else begin
               hdr_count = hdr_count + 3'd1;
            end
         end
         P_KEY: begin
            frame_key = {frame_key[23:0], b};
            hdr_count = hdr_count + 3'd1;
            if (hdr_count == 3'd4) header_done(emitted, res);
         end
         P_DATA: begin
            kb = frame_mask ? frame_key[31 - 8 * key_pos -: 8] : 8'h00;
            fin_last = (bytes_remaining <= 63'd1);
            emitted = 1'b1;
            res = frame_item(wsdf_pkg::KIND_PAYLOAD, b ^ kb, fin_last);
            key_pos = key_pos + 2'd1;
            if (fin_last) begin
               bytes_remaining = 63'd0;
               frame_phase = P_HDR0;
            end else begin
               bytes_remaining = bytes_remaining - 63'd1;
            end
         end
         default: frame_phase = P_HDR0;
      endcase
   endtask

   task automatic push_byte(input logic [7:0] b);
      stimulus.push_back('{rx_byte: b, typed: 1'b0, want: '0});
   endtask

   task automatic queue_frame(input logic [7:0] first, input logic mask,
                              input len_form_type form, input logic [63:0] len,
                              input int body);
      logic [31:0] key;
      logic [6:0]  len7;
      case ($urandom_range(0, 5))
         0: key = 32'h0000_0000;
         1: key = 32'hFFFF_FFFF;
         default: key = $urandom;
      endcase
      len7 = (form == FORM_SHORT) ? len[6:0] :
             (form == FORM_EXT16) ? wsdf_pkg::LEN7_EXT16 : wsdf_pkg::LEN7_EXT64;
      push_byte(first);
      push_byte({mask, len7});
      if (form == FORM_EXT16) for (int i = 1; i >= 0; i--) push_byte(len[8 * i +: 8]);
      if (form == FORM_EXT64) for (int i = 7; i >= 0; i--) push_byte(len[8 * i +: 8]);
      if (mask) for (int i = 3; i >= 0; i--) push_byte(key[8 * i +: 8]);
      repeat (body) push_byte(8'($urandom_range(0, 255)));
      frames_built++;
   endtask

   task automatic report_mismatch(input string what, input logic [62:0] got,
                                  input logic [62:0] want);
      mismatches++;
      $display("cycle %0d: %s mismatch, got %0h want %0h", cycle, what, got, want);
   endtask

   initial begin : sender
      int                burst;
      int                gap;
      int                idx;
      int                n;
      int                pick;
      len_form_type      form;
      logic [63:0]       len;
      logic              got;
      wsdf_pkg::rsp_type res;

      directed_rows = '{
         '{8'h81, 1'b0, '0},
         '{8'h00, 1'b1, '{wsdf_pkg::KIND_HEADER, 8'h00, 1'b1, 4'h1, 1'b0, 63'd0, 1'b1}},
         '{8'h72, 1'b0, '0},
         '{8'hFE, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'h01, 1'b0, '0},
         '{8'hFF, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'h00, 1'b1, '{wsdf_pkg::KIND_HEADER, 8'h00, 1'b0, 4'h2, 1'b1, 63'd1, 1'b0}},
         '{8'hFF, 1'b1, '{wsdf_pkg::KIND_PAYLOAD, 8'h00, 1'b0, 4'h2, 1'b1, 63'd1, 1'b1}},
         '{8'h8F, 1'b0, '0},
         '{8'hFF, 1'b0, '0},
         '{8'h80, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'h00, 1'b0, '0},
         '{8'hAA, 1'b0, '0},
         '{8'hBB, 1'b0, '0},
         '{8'hCC, 1'b0, '0},
         '{8'hDD, 1'b1, '{wsdf_pkg::KIND_HEADER, 8'h00, 1'b1, 4'hF, 1'b1, 63'd0, 1'b1}}
      };
      foreach (directed_rows[i]) stimulus.push_back(directed_rows[i]);

      while (stimulus.size() < $size(directed_rows) + RANDOM_BYTES) begin
         pick = $urandom_range(0, 19);
         if (pick < 13) n = $urandom_range(0, 8);
         else if (pick < 19) n = $urandom_range(9, 40);
         else n = $urandom_range(100, 300);
         case ($urandom_range(0, 3))
            0: form = FORM_EXT16;
            1: form = FORM_EXT64;
            default: form = FORM_SHORT;
         endcase
         if (form == FORM_SHORT && n > 125) form = FORM_EXT16;
         len = 64'(n);
         if (form == FORM_EXT64) len[63] = 1'($urandom_range(0, 1));
         queue_frame(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), form, len, n);
      end
      // longest possible length, left unfinished
      queue_frame(8'h82, 1'b1, FORM_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 6);

      do @(posedge clock); while (reset);

      idx = 0;
      while (idx < stimulus.size()) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 30);
         req_valid <= 1'b1;
         req_rx_byte <= stimulus[idx].rx_byte;
         while (burst > 0 && idx < stimulus.size()) begin
            @(posedge clock);
            if (!req_stall) begin
               deframe_byte(stimulus[idx].rx_byte, got, res);
               if (stimulus[idx].typed) res = stimulus[idx].want;
               if (got || stimulus[idx].typed) awaited_items.push_back(res);
               accepted_bytes++;
               idx++;
               burst--;
               if (burst > 0 && idx < stimulus.size()) req_rx_byte <= stimulus[idx].rx_byte;
            end
         end
         req_valid <= 1'b0;
         gap = $urandom_range(1, 8);
         repeat (gap) @(posedge clock);
      end
      stim_done = 1'b1;
   end

   initial begin : receiver
      int mode;
      int span;
      forever begin
         if (!held_off && accepted_bytes >= 300) begin
            held_off = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 120);
            for (int k = 0; k < span; k++) begin
               @(posedge clock);
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= ($urandom_range(0, 3) != 0);
                  default: rsp_stall <= ((k % 5) < 2);
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin : check
      wsdf_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_items.size() == 0) begin
            report_mismatch("unexpected item", 63'd0, 63'd0);
         end else begin
            want = awaited_items.pop_front();
            if (want.kind == wsdf_pkg::KIND_HEADER) headers_seen++;
            else payload_seen++;
            if (rsp_kind !== want.kind)
               report_mismatch("kind", 63'(rsp_kind), 63'(want.kind));
            if (rsp_payload_byte !== want.payload_byte)
               report_mismatch("payload_byte", 63'(rsp_payload_byte), 63'(want.payload_byte));
            if (rsp_fin !== want.fin)
               report_mismatch("fin", 63'(rsp_fin), 63'(want.fin));
            if (rsp_frame_opcode !== want.frame_opcode)
               report_mismatch("frame_opcode", 63'(rsp_frame_opcode), 63'(want.frame_opcode));
            if (rsp_masked !== want.masked)
               report_mismatch("masked", 63'(rsp_masked), 63'(want.masked));
            if (rsp_payload_length !== want.payload_length)
               report_mismatch("payload_length", rsp_payload_length, want.payload_length);
            if (rsp_last !== want.last)
               report_mismatch("last", 63'(rsp_last), 63'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (req_valid && req_stall) hold_run <= hold_run + 1;
      else hold_run <= 0;
      if (hold_run > longest_hold) longest_hold <= hold_run;
      if (cycle >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done);
      while (awaited_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d input bytes in %0d frames; %0d headers and %0d payload items checked",
               accepted_bytes, frames_built, headers_seen, payload_seen);
      $display("longest input hold %0d cycles, %0d mismatches", longest_hold, mismatches);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
